FILE: rtl/tnf_pkg.sv
// Shared types and constants for the triangle tangent frame block.
// Used by tnf_arith and by the top level triangle_normal_tangent_frame.
`default_nettype none
package tnf_pkg;

	localparam int COORD_BITS_DEF = 32;

	// normal scaling: magnitudes normalized to 31 bits, unit length is 2^30
	localparam int NORM_MAG_BITS  = 31;
	localparam int NORM_ONE_SHIFT = 30;
	// tangent and bitangent fraction bits
	localparam int UV_FRAC        = 16;
	// squared length fits in 64 bits; its root takes 32 steps
	localparam int LEN2_BITS      = 64;
	localparam int SQRT_STEPS     = 32;
	localparam int OUT_BITS       = 32;

	localparam logic [OUT_BITS-1:0] SAT_POS = 32'h7FFF_FFFF;
	localparam logic [OUT_BITS-1:0] SAT_NEG = 32'h8000_0000;

	typedef logic [1:0] arith_op_t;
	localparam arith_op_t OP_MUL  = 2'd0;
	localparam arith_op_t OP_DIV  = 2'd1;
	localparam arith_op_t OP_SQRT = 2'd2;

	typedef struct packed {
		logic      start;
		arith_op_t op;
	} arith_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} arith_sts_t;

endpackage
`default_nettype wire

FILE: rtl/tnf_arith.sv
// Shared bit-serial arithmetic unit: unsigned multiply, restoring divide, integer square root.
// One bit (root: one digit) per cycle. Depends on tnf_pkg.
`default_nettype none
module tnf_arith #(
	parameter int W    = 84,
	parameter int MULB = 33
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire tnf_pkg::arith_cmd_t cmd,
	input  wire logic [W-1:0]        opa,
	input  wire logic [W-1:0]        opb,
	output tnf_pkg::arith_sts_t      sts,
	output logic [W-1:0]             result
);
	localparam int CW = $clog2(W + 1);

	tnf_pkg::arith_op_t op_q;
	logic               busy_q;
	logic               done_q;
	logic [CW-1:0]      cnt_q;
	logic [W-1:0]       x_q;
	logic [W-1:0]       y_q;
	logic [W:0]         r_q;

	logic [W-1:0] mul_sum;
	logic [W:0]   div_sh;
	logic         div_ge;
	logic [W:0]   sq_sh;
	logic [W:0]   sq_trial;
	logic         sq_ge;

	assign mul_sum  = r_q[W-1:0] + x_q;
	assign div_sh   = {r_q[W-1:0], x_q[W-1]};
	assign div_ge   = div_sh >= {1'b0, y_q};
	assign sq_sh    = {r_q[W-2:0], x_q[tnf_pkg::LEN2_BITS-1 -: 2]};
	assign sq_trial = {y_q[W-2:0], 2'b01};
	assign sq_ge    = sq_sh >= sq_trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q   <= tnf_pkg::OP_MUL;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				op_q   <= cmd.op;
				busy_q <= 1'b1;
				case (cmd.op)
					tnf_pkg::OP_MUL:  cnt_q <= CW'(MULB);
					tnf_pkg::OP_DIV:  cnt_q <= CW'(W);
					default:          cnt_q <= CW'(tnf_pkg::SQRT_STEPS);
				endcase
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			r_q <= '0;
			x_q <= opa;
			y_q <= (cmd.op == tnf_pkg::OP_SQRT) ? '0 : opb;
		end else if (busy_q) begin
			case (op_q)
				tnf_pkg::OP_MUL: begin
					if (y_q[0])
						r_q <= {1'b0, mul_sum};
					x_q <= x_q << 1;
					y_q <= y_q >> 1;
				end
				tnf_pkg::OP_DIV: begin
					r_q <= div_ge ? (div_sh - {1'b0, y_q}) : div_sh;
					x_q <= {x_q[W-2:0], div_ge};
				end
				tnf_pkg::OP_SQRT: begin
					r_q <= sq_ge ? (sq_sh - sq_trial) : sq_sh;
					y_q <= {y_q[W-2:0], sq_ge};
					x_q <= x_q << 2;
				end
				default: begin
					r_q <= r_q;
				end
			endcase
		end
	end

	always_comb begin
		case (op_q)
			tnf_pkg::OP_MUL:  result = r_q[W-1:0];
			tnf_pkg::OP_DIV:  result = x_q;
			tnf_pkg::OP_SQRT: result = y_q;
			default:          result = '0;
		endcase
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;

endmodule
`default_nettype wire

FILE: rtl/triangle_normal_tangent_frame.sv
// Per-triangle tangent frame: unit normal (Q2.30), tangent and bitangent (Q16.16, saturated).
// Top level: corner storage, sequencer and result registers. Depends on tnf_pkg, tnf_arith.
//
// Usage: corners come in on the input channel (in_valid/in_ready), one beat per corner,
// three beats per triangle. The first two corners are taken whenever the block is idle
// and give no result. The third corner starts the frame computation; in_ready stays
// low until it is finished and handed to the output register. One result beat per
// triangle leaves on the output channel (out_valid/out_ready).
// The third corner sets off, in order: 20 products, up to max(30, 2*COORD_BITS-30)
// normalize shifts, 3 squares, a root and 9 divides. All but the shifts are done by the
// single bit-serial unit tnf_arith, which does every multiply, divide and root one bit
// per cycle; it runs with MULB = max(COORD_BITS+1, 31) and W = max(2*COORD_BITS+20, 64).
// A triangle with zero area or a zero uv determinant skips that part of the work.
// A stalled receiver holds the result in the output register; the first two corners
// of the next triangle are still taken, the third waits until the register frees.
// Reset (arst_n low) clears the held corners and the corner count and drops out_valid.
`default_nettype none
module triangle_normal_tangent_frame #(
	parameter int COORD_BITS = tnf_pkg::COORD_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [COORD_BITS-1:0]  pos_x,
	input  wire logic signed [COORD_BITS-1:0]  pos_y,
	input  wire logic signed [COORD_BITS-1:0]  pos_z,
	input  wire logic signed [COORD_BITS-1:0]  tex_u,
	input  wire logic signed [COORD_BITS-1:0]  tex_v,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [31:0]                 normal_x,
	output logic signed [31:0]                 normal_y,
	output logic signed [31:0]                 normal_z,
	output logic signed [31:0]                 tangent_x,
	output logic signed [31:0]                 tangent_y,
	output logic signed [31:0]                 tangent_z,
	output logic signed [31:0]                 bitangent_x,
	output logic signed [31:0]                 bitangent_y,
	output logic signed [31:0]                 bitangent_z,
	output logic [1:0]                         frame_status
);
	localparam int CB   = COORD_BITS;
	localparam int MB   = CB + 1;
	localparam int MULB = (MB > tnf_pkg::NORM_MAG_BITS) ? MB : tnf_pkg::NORM_MAG_BITS;
	localparam int W    = (2 * CB + 20 > tnf_pkg::LEN2_BITS) ? 2 * CB + 20 : tnf_pkg::LEN2_BITS;
	localparam int MB31 = tnf_pkg::NORM_MAG_BITS;
	localparam int OB   = tnf_pkg::OUT_BITS;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_TERM   = 4'd1;
	localparam logic [3:0] S_TERM_W = 4'd2;
	localparam logic [3:0] S_NPREP  = 4'd3;
	localparam logic [3:0] S_NORM   = 4'd4;
	localparam logic [3:0] S_SQ     = 4'd5;
	localparam logic [3:0] S_SQ_W   = 4'd6;
	localparam logic [3:0] S_SQRT   = 4'd7;
	localparam logic [3:0] S_SQRT_W = 4'd8;
	localparam logic [3:0] S_NDIV   = 4'd9;
	localparam logic [3:0] S_NDIV_W = 4'd10;
	localparam logic [3:0] S_TSET   = 4'd11;
	localparam logic [3:0] S_TDIV   = 4'd12;
	localparam logic [3:0] S_TDIV_W = 4'd13;
	localparam logic [3:0] S_DONE   = 4'd14;

	// term slots: cross x/y/z, uv determinant, tangent numerators, bitangent numerators
	localparam logic [3:0] T_DET   = 4'd3;
	localparam logic [3:0] T_TAN0  = 4'd4;
	localparam logic [3:0] T_LAST  = 4'd9;

	function automatic logic signed [MB-1:0] dif(input logic [CB-1:0] a, input logic [CB-1:0] b);
		return $signed({a[CB-1], a}) - $signed({b[CB-1], b});
	endfunction

	function automatic logic [W-1:0] absw(input logic [W-1:0] v);
		return v[W-1] ? (~v + W'(1)) : v;
	endfunction

	logic [3:0]               state_q;
	logic [1:0]               corner_cnt_q;
	logic [3:0]               idx_q;
	logic                     half_q;
	logic                     out_valid_q;
	logic [CB-1:0]            hpos_q [2][3];
	logic [CB-1:0]            huv_q  [2][2];

	logic signed [MB-1:0]     e1_q [3];
	logic signed [MB-1:0]     e2_q [3];
	logic signed [MB-1:0]     d1u_q, d1v_q, d2u_q, d2v_q;
	logic                     psign_q;
	logic [W-1:0]             acc_q;
	logic [W-1:0]             terms_q [10];
	logic [W-1:0]             mag_q [3];
	logic                     neg_q [3];
	logic                     zero_area_q;
	logic                     det_zero_q;
	logic [tnf_pkg::LEN2_BITS-1:0] len2_q;
	logic [tnf_pkg::SQRT_STEPS-1:0] len_q;
	logic [OB-1:0]            nrm_q [3];
	logic [OB-1:0]            tb_q [6];
	logic [OB-1:0]            out_nrm_q [3];
	logic [OB-1:0]            out_tb_q [6];
	logic [1:0]               out_status_q;

	tnf_pkg::arith_cmd_t cmd;
	tnf_pkg::arith_sts_t sts;
	logic [W-1:0]        u_opa, u_opb, u_res;

	logic                 accept, third, can_load, done;
	logic signed [MB-1:0] opa_s, opb_s;
	logic [MB-1:0]        mag_a, mag_b;
	logic                 psign, sub_sign;
	logic [W-1:0]         term_val;
	logic                 zero_area;
	logic [W-1:0]         orv;
	logic                 norm_hi, norm_ok;
	logic [MB31-1:0]      m_sel;
	logic [3:0]           tidx;
	logic [W-1:0]         tnum, tnum_abs, det_abs;
	logic                 tneg;
	logic [OB-1:0]        tsat;
	logic [OB-1:0]        nq;

	assign in_ready = (state_q == S_IDLE) && (!corner_cnt_q[1] || can_load);
	assign accept   = in_valid && in_ready;
	assign third    = accept && corner_cnt_q[1];
	assign can_load = !out_valid_q || out_ready;
	assign done     = sts.done;

	// product operands per term: first half is the positive product, second is subtracted
	always_comb begin
		case (idx_q)
			4'd0:    begin opa_s = half_q ? e2_q[2] : e2_q[1]; opb_s = half_q ? e1_q[1] : e1_q[2]; end
			4'd1:    begin opa_s = half_q ? e2_q[0] : e2_q[2]; opb_s = half_q ? e1_q[2] : e1_q[0]; end
			4'd2:    begin opa_s = half_q ? e2_q[1] : e2_q[0]; opb_s = half_q ? e1_q[0] : e1_q[1]; end
			4'd3:    begin opa_s = half_q ? d1v_q : d1u_q; opb_s = half_q ? d2u_q : d2v_q; end
			4'd4:    begin opa_s = half_q ? d1v_q : d2v_q; opb_s = half_q ? e2_q[0] : e1_q[0]; end
			4'd5:    begin opa_s = half_q ? d1v_q : d2v_q; opb_s = half_q ? e2_q[1] : e1_q[1]; end
			4'd6:    begin opa_s = half_q ? d1v_q : d2v_q; opb_s = half_q ? e2_q[2] : e1_q[2]; end
			4'd7:    begin opa_s = half_q ? d2u_q : d1u_q; opb_s = half_q ? e1_q[0] : e2_q[0]; end
			4'd8:    begin opa_s = half_q ? d2u_q : d1u_q; opb_s = half_q ? e1_q[1] : e2_q[1]; end
			4'd9:    begin opa_s = half_q ? d2u_q : d1u_q; opb_s = half_q ? e1_q[2] : e2_q[2]; end
			default: begin opa_s = '0; opb_s = '0; end
		endcase
	end

	assign mag_a    = opa_s[MB-1] ? MB'(-opa_s) : MB'(opa_s);
	assign mag_b    = opb_s[MB-1] ? MB'(-opb_s) : MB'(opb_s);
	assign psign    = opa_s[MB-1] ^ opb_s[MB-1];
	assign sub_sign = psign_q ^ half_q;
	assign term_val = (half_q ? acc_q : '0) + (sub_sign ? ~u_res : u_res) + W'(sub_sign);

	assign zero_area = (terms_q[0] == '0) && (terms_q[1] == '0) && (terms_q[2] == '0);
	assign orv       = mag_q[0] | mag_q[1] | mag_q[2];
	assign norm_hi   = |orv[W-1:MB31];
	assign norm_ok   = orv[MB31-1];
	assign m_sel     = mag_q[idx_q[1:0]][MB31-1:0];

	assign tidx     = idx_q + T_TAN0;
	assign tnum     = terms_q[tidx];
	assign tnum_abs = absw(tnum);
	assign det_abs  = absw(terms_q[T_DET]);
	assign tneg     = tnum[W-1] ^ terms_q[T_DET][W-1];

	always_comb begin
		if (!tneg)
			tsat = (|u_res[W-1:OB-1]) ? tnf_pkg::SAT_POS : u_res[OB-1:0];
		else if ((|u_res[W-1:OB]) || (u_res[OB-1] && (|u_res[OB-2:0])))
			tsat = tnf_pkg::SAT_NEG;
		else
			tsat = -u_res[OB-1:0];
	end

	assign nq = u_res[OB-1:0];

	// unit command and operands
	always_comb begin
		cmd.start = (state_q == S_TERM) || (state_q == S_SQ) || (state_q == S_SQRT) ||
			(state_q == S_NDIV) || (state_q == S_TDIV);
		u_opa = '0;
		u_opb = '0;
		case (state_q)
			S_TERM: begin
				cmd.op = tnf_pkg::OP_MUL;
				u_opa  = W'(mag_a);
				u_opb  = W'(mag_b);
			end
			S_SQ: begin
				cmd.op = tnf_pkg::OP_MUL;
				u_opa  = W'(m_sel);
				u_opb  = W'(m_sel);
			end
			S_SQRT: begin
				cmd.op = tnf_pkg::OP_SQRT;
				u_opa  = W'(len2_q);
			end
			S_NDIV: begin
				cmd.op = tnf_pkg::OP_DIV;
				u_opa  = (W'(m_sel) << tnf_pkg::NORM_ONE_SHIFT) + W'(len_q[tnf_pkg::SQRT_STEPS-1:1]);
				u_opb  = W'(len_q);
			end
			S_TDIV: begin
				cmd.op = tnf_pkg::OP_DIV;
				u_opa  = tnum_abs << tnf_pkg::UV_FRAC;
				u_opb  = det_abs;
			end
			default: begin
				cmd.op = tnf_pkg::OP_MUL;
			end
		endcase
	end

	tnf_arith #(
		.W    (W),
		.MULB (MULB)
	) u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.opa    (u_opa),
		.opb    (u_opb),
		.sts    (sts),
		.result (u_res)
	);

	// sequencer and held corners
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			corner_cnt_q <= '0;
			idx_q        <= '0;
			half_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			for (int c = 0; c < 2; c++) begin
				for (int k = 0; k < 3; k++)
					hpos_q[c][k] <= '0;
				for (int k = 0; k < 2; k++)
					huv_q[c][k] <= '0;
			end
		end else begin
			if (state_q == S_DONE && can_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (!corner_cnt_q[1]) begin
							hpos_q[corner_cnt_q[0]][0] <= pos_x;
							hpos_q[corner_cnt_q[0]][1] <= pos_y;
							hpos_q[corner_cnt_q[0]][2] <= pos_z;
							huv_q[corner_cnt_q[0]][0]  <= tex_u;
							huv_q[corner_cnt_q[0]][1]  <= tex_v;
							corner_cnt_q <= corner_cnt_q + 2'd1;
						end else begin
							corner_cnt_q <= '0;
							idx_q        <= '0;
							half_q       <= 1'b0;
							state_q      <= S_TERM;
						end
					end
				end
				S_TERM: state_q <= S_TERM_W;
				S_TERM_W: begin
					if (done) begin
						if (!half_q) begin
							half_q  <= 1'b1;
							state_q <= S_TERM;
						end else begin
							half_q <= 1'b0;
							if (idx_q == T_LAST) begin
								state_q <= S_NPREP;
							end else begin
								idx_q   <= idx_q + 4'd1;
								state_q <= S_TERM;
							end
						end
					end
				end
				S_NPREP: state_q <= zero_area ? S_TSET : S_NORM;
				S_NORM: begin
					if (!norm_hi && norm_ok) begin
						idx_q   <= '0;
						state_q <= S_SQ;
					end
				end
				S_SQ: state_q <= S_SQ_W;
				S_SQ_W: begin
					if (done) begin
						if (idx_q == 4'd2) begin
							state_q <= S_SQRT;
						end else begin
							idx_q   <= idx_q + 4'd1;
							state_q <= S_SQ;
						end
					end
				end
				S_SQRT: state_q <= S_SQRT_W;
				S_SQRT_W: begin
					if (done) begin
						idx_q   <= '0;
						state_q <= S_NDIV;
					end
				end
				S_NDIV: state_q <= S_NDIV_W;
				S_NDIV_W: begin
					if (done) begin
						if (idx_q == 4'd2) begin
							state_q <= S_TSET;
						end else begin
							idx_q   <= idx_q + 4'd1;
							state_q <= S_NDIV;
						end
					end
				end
				S_TSET: begin
					idx_q   <= '0;
					state_q <= det_zero_q ? S_DONE : S_TDIV;
				end
				S_TDIV: state_q <= S_TDIV_W;
				S_TDIV_W: begin
					if (done) begin
						if (idx_q == 4'd5) begin
							state_q <= S_DONE;
						end else begin
							idx_q   <= idx_q + 4'd1;
							state_q <= S_TDIV;
						end
					end
				end
				S_DONE: begin
					if (can_load)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (third) begin
			e1_q[0] <= dif(hpos_q[0][0], hpos_q[1][0]);
			e1_q[1] <= dif(hpos_q[0][1], hpos_q[1][1]);
			e1_q[2] <= dif(hpos_q[0][2], hpos_q[1][2]);
			e2_q[0] <= dif(pos_x, hpos_q[1][0]);
			e2_q[1] <= dif(pos_y, hpos_q[1][1]);
			e2_q[2] <= dif(pos_z, hpos_q[1][2]);
			d1u_q   <= dif(huv_q[0][0], huv_q[1][0]);
			d1v_q   <= dif(huv_q[0][1], huv_q[1][1]);
			d2u_q   <= dif(tex_u, huv_q[1][0]);
			d2v_q   <= dif(tex_v, huv_q[1][1]);
		end

		case (state_q)
			S_TERM: psign_q <= psign;
			S_TERM_W: begin
				if (done) begin
					if (!half_q)
						acc_q <= term_val;
					else
						terms_q[idx_q] <= term_val;
				end
			end
			S_NPREP: begin
				for (int i = 0; i < 3; i++) begin
					mag_q[i] <= absw(terms_q[i]);
					neg_q[i] <= terms_q[i][W-1];
					if (zero_area)
						nrm_q[i] <= '0;
				end
				zero_area_q <= zero_area;
				det_zero_q  <= (terms_q[T_DET] == '0);
				len2_q      <= '0;
			end
			S_NORM: begin
				// shift the three magnitudes together until the widest has 31 bits
				for (int i = 0; i < 3; i++) begin
					if (norm_hi)
						mag_q[i] <= mag_q[i] >> 1;
					else if (!norm_ok)
						mag_q[i] <= mag_q[i] << 1;
				end
			end
			S_SQ_W: begin
				if (done)
					len2_q <= len2_q + u_res[tnf_pkg::LEN2_BITS-1:0];
			end
			S_SQRT_W: begin
				if (done)
					len_q <= u_res[tnf_pkg::SQRT_STEPS-1:0];
			end
			S_NDIV_W: begin
				if (done)
					nrm_q[idx_q[1:0]] <= neg_q[idx_q[1:0]] ? -nq : nq;
			end
			S_TSET: begin
				if (det_zero_q)
					for (int i = 0; i < 6; i++)
						tb_q[i] <= '0;
			end
			S_TDIV_W: begin
				if (done)
					tb_q[idx_q[2:0]] <= tsat;
			end
			S_DONE: begin
				if (can_load) begin
					for (int i = 0; i < 3; i++)
						out_nrm_q[i] <= nrm_q[i];
					for (int i = 0; i < 6; i++)
						out_tb_q[i] <= tb_q[i];
					out_status_q <= {det_zero_q, zero_area_q};
				end
			end
			default: begin
				psign_q <= psign_q;
			end
		endcase
	end

	assign out_valid    = out_valid_q;
	assign normal_x     = out_nrm_q[0];
	assign normal_y     = out_nrm_q[1];
	assign normal_z     = out_nrm_q[2];
	assign tangent_x    = out_tb_q[0];
	assign tangent_y    = out_tb_q[1];
	assign tangent_z    = out_tb_q[2];
	assign bitangent_x  = out_tb_q[3];
	assign bitangent_y  = out_tb_q[4];
	assign bitangent_z  = out_tb_q[5];
	assign frame_status = out_status_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> !sts.busy) else $error("arith unit started while busy");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		corner_cnt_q != 2'd3) else $error("corner count out of range");

	a_third_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && corner_cnt_q[1]) |=> !in_ready)
		else $error("input taken during frame computation");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_DONE)
		else $error("result raised outside the finish state");

endmodule
`default_nettype wire

FILE: dv/triangle_normal_tangent_frame_test.sv
// Self-checking testbench for the per-triangle tangent frame block.
// Depends on tnf_pkg and triangle_normal_tangent_frame; predicts each frame internally.
`timescale 1ns / 1ps
module triangle_normal_tangent_frame_test;

	localparam logic [1:0] ST_ZERO_AREA = 2'b01;
	localparam logic [1:0] ST_ZERO_DET  = 2'b10;
	localparam int         MAX_SHOWN    = 20;

	typedef struct {
		logic signed [31:0] pos [3];
		logic signed [31:0] uv  [2];
	} corner_t;

	typedef struct {
		logic [31:0] nrm [3];
		logic [31:0] tan [3];
		logic [31:0] btn [3];
		logic [1:0]  status;
	} frame_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0, tex_u = '0, tex_v = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] normal_x, normal_y, normal_z;
	logic signed [31:0] tangent_x, tangent_y, tangent_z;
	logic signed [31:0] bitangent_x, bitangent_y, bitangent_z;
	logic [1:0] frame_status;

	triangle_normal_tangent_frame i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .tex_u(tex_u), .tex_v(tex_v),
		.out_valid(out_valid), .out_ready(out_ready),
		.normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
		.tangent_x(tangent_x), .tangent_y(tangent_y), .tangent_z(tangent_z),
		.bitangent_x(bitangent_x), .bitangent_y(bitangent_y), .bitangent_z(bitangent_z),
		.frame_status(frame_status)
	);

	always #5 clk = ~clk;

	frame_t  pending_frames [$];
	corner_t held_corners [2];
	int      corner_count = 0;
	int      error_count = 0;
	int      frames_seen = 0;
	int      flat_seen = 0;
	int      no_det_seen = 0;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		error_count++;
		if (error_count <= MAX_SHOWN)
			$display("MISMATCH frame %0d %s: got %h expected %h", frames_seen, what, got, want);
	endtask

	function automatic logic [63:0] isqrt(input logic [63:0] x);
		logic [63:0] res, bit_w;
		res = '0;
		bit_w = 64'd1 << 62;
		while (bit_w > x) bit_w = bit_w >> 2;
		while (bit_w != 0) begin
			if (x >= res + bit_w) begin
				x = x - (res + bit_w);
				res = (res >> 1) + bit_w;
			end else begin
				res = res >> 1;
			end
			bit_w = bit_w >> 2;
		end
		return res;
	endfunction

	function automatic logic [31:0] scaled_quot(input logic signed [127:0] num,
			input logic signed [127:0] det);
		logic neg;
		logic [127:0] q, an, ad;
		neg = num[127] ^ det[127];
		an = num[127] ? -num : num;
		ad = det[127] ? -det : det;
		q = (an << tnf_pkg::UV_FRAC) / ad;
		if (!neg)
			return (q > 128'h7FFF_FFFF) ? tnf_pkg::SAT_POS : q[31:0];
		return (q > 128'h8000_0000) ? tnf_pkg::SAT_NEG : 32'(-q);
	endfunction

	function automatic frame_t predict_frame(input corner_t c0, input corner_t c1,
			input corner_t c2);
		frame_t f;
		logic signed [127:0] e1 [3], e2 [3], cr [3], mag [3];
		logic signed [127:0] d1u, d1v, d2u, d2v, det, tn, bn;
		logic [127:0] orv, s;
		logic [63:0] m [3], len2, len, q;
		int bl;
		for (int i = 0; i < 3; i++) begin
			e1[i] = c0.pos[i];
			e1[i] = e1[i] - c1.pos[i];
			e2[i] = c2.pos[i];
			e2[i] = e2[i] - c1.pos[i];
		end
		d1u = c0.uv[0]; d1u = d1u - c1.uv[0];
		d1v = c0.uv[1]; d1v = d1v - c1.uv[1];
		d2u = c2.uv[0]; d2u = d2u - c1.uv[0];
		d2v = c2.uv[1]; d2v = d2v - c1.uv[1];
		cr[0] = e2[1] * e1[2] - e2[2] * e1[1];
		cr[1] = e2[2] * e1[0] - e2[0] * e1[2];
		cr[2] = e2[0] * e1[1] - e2[1] * e1[0];
		orv = '0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = cr[i][127] ? -cr[i] : cr[i];
			orv = orv | mag[i];
		end
		f.status = '0;
		if (orv == 0) begin
			f.status |= ST_ZERO_AREA;
			for (int i = 0; i < 3; i++) f.nrm[i] = '0;
		end else begin
			bl = 0;
			for (int i = 0; i < 128; i++) if (orv[i]) bl = i + 1;
			len2 = '0;
			for (int i = 0; i < 3; i++) begin
				s = (bl > tnf_pkg::NORM_MAG_BITS) ? (mag[i] >> (bl - tnf_pkg::NORM_MAG_BITS))
				                                  : (mag[i] << (tnf_pkg::NORM_MAG_BITS - bl));
				m[i] = s[63:0];
				len2 = len2 + m[i] * m[i];
			end
			len = isqrt(len2);
			for (int i = 0; i < 3; i++) begin
				q = ((m[i] << tnf_pkg::NORM_ONE_SHIFT) + (len >> 1)) / len;
				f.nrm[i] = cr[i][127] ? 32'(-q) : q[31:0];
			end
		end
		det = d1u * d2v - d1v * d2u;
		if (det == 0) begin
			f.status |= ST_ZERO_DET;
			for (int i = 0; i < 3; i++) begin
				f.tan[i] = '0;
				f.btn[i] = '0;
			end
		end else begin
			for (int i = 0; i < 3; i++) begin
				tn = d2v * e1[i] - d1v * e2[i];
				bn = d1u * e2[i] - d2u * e1[i];
				f.tan[i] = scaled_quot(tn, det);
				f.btn[i] = scaled_quot(bn, det);
			end
		end
		return f;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 4);
		return $urandom_range(20, 90);
	endfunction

	// Send one corner beat; called and returning at a falling edge.
	task automatic send_corner(input corner_t c);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pos_x <= c.pos[0]; pos_y <= c.pos[1]; pos_z <= c.pos[2];
		tex_u <= c.uv[0];  tex_v <= c.uv[1];
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		if (corner_count < 2) begin
			held_corners[corner_count] = c;
			corner_count++;
		end else begin
			pending_frames.insert(pending_frames.size(),
				predict_frame(held_corners[0], held_corners[1], c));
			corner_count = 0;
		end
		@(negedge clk);
	endtask

	function automatic corner_t mk(input int x, input int y, input int z, input int u,
			input int v);
		corner_t c;
		c.pos[0] = x; c.pos[1] = y; c.pos[2] = z; c.uv[0] = u; c.uv[1] = v;
		return c;
	endfunction

	task automatic send_triangle(input corner_t a, input corner_t b, input corner_t c);
		send_corner(a);
		send_corner(b);
		send_corner(c);
	endtask

	task automatic test_basic_frames();
		localparam int ONE = 32'h0001_0000;
		send_triangle(mk(ONE, 0, 0, ONE, 0), mk(0, 0, 0, 0, 0), mk(0, ONE, 0, 0, ONE));
		send_triangle(mk(0, 0, ONE, 0, 0), mk(ONE, 0, 0, ONE, 0), mk(0, ONE, 0, 0, ONE));
		send_triangle(mk(-ONE, 3 * ONE, 5, 7, -ONE), mk(2, -9, ONE, ONE, 3),
			mk(ONE / 2, ONE, -ONE, -5, ONE));
	endtask

	task automatic test_degenerate();
		corner_t p;
		p = mk(1234, -5678, 42, 99, 77);
		// all corners coincide: both flags
		send_triangle(p, p, p);
		// collinear positions, valid uv
		send_triangle(mk(0, 0, 0, 0, 0), mk(100, 200, 300, 500, 0),
			mk(300, 600, 900, 0, 500));
		// proper area, uv all equal
		send_triangle(mk(100, 0, 0, 7, 7), mk(0, 0, 0, 7, 7), mk(0, 100, 0, 7, 7));
	endtask

	task automatic test_extremes();
		int mx, mn;
		mx = 32'h7FFF_FFFF;
		mn = 32'h8000_0000;
		send_triangle(mk(mx, mx, mn, mx, mn), mk(mn, mn, mx, mn, mx), mk(mx, mn, mx, mn, mn));
		// tiny uv determinant drives tangents into saturation
		send_triangle(mk(mx, 0, mn, 1, 0), mk(mn, mx, 0, 0, 0), mk(0, mn, mx, 0, 1));
		send_triangle(mk(mn, -1, 0, -1, mx), mk(-1, mn, mx, mx, -1), mk(mx, 1, -1, mn, 0));
	endtask

	function automatic int rand_coord(input int kind);
		case (kind)
			0: return $urandom;
			1: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
			default: return $urandom_range(0, 64) - 32;
		endcase
	endfunction

	function automatic corner_t rand_corner(input int kind);
		corner_t c;
		for (int i = 0; i < 3; i++) c.pos[i] = rand_coord(kind);
		for (int i = 0; i < 2; i++) c.uv[i] = rand_coord(kind);
		return c;
	endfunction

	task automatic test_random(input int n_tri);
		corner_t a, b, c;
		int kind, shape;
		for (int t = 0; t < n_tri; t++) begin
			kind = $urandom_range(0, 2);
			a = rand_corner(kind);
			b = rand_corner($urandom_range(0, 3) == 0 ? $urandom_range(0, 2) : kind);
			c = rand_corner(kind);
			shape = $urandom_range(0, 9);
			if (shape == 0) begin
				c.pos = b.pos;
			end else if (shape == 1) begin
				// collinear: third corner on the line through the others
				for (int i = 0; i < 3; i++) c.pos[i] = 2 * b.pos[i] - a.pos[i];
			end else if (shape == 2) begin
				c.uv = b.uv;
			end else if (shape == 3) begin
				for (int i = 0; i < 2; i++) c.uv[i] = 3 * b.uv[i] - 2 * a.uv[i];
			end
			send_triangle(a, b, c);
		end
	endtask

	// receiver: random stalls, mostly short
	initial begin
		int hold;
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 2) == 0) begin
				out_ready <= 1'b1;
			end else begin
				hold = pick_gap();
				if (hold == 0) begin
					out_ready <= 1'b1;
				end else begin
					out_ready <= 1'b0;
					repeat (hold) @(negedge clk);
					out_ready <= 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin
		frame_t w;
		if (arst_n && out_valid && out_ready) begin
			if (pending_frames.size() == 0) begin
				report_mismatch("unexpected frame", {30'b0, frame_status}, '0);
			end else begin
				w = pending_frames.pop_front();
				if (normal_x != w.nrm[0]) report_mismatch("normal_x", normal_x, w.nrm[0]);
				if (normal_y != w.nrm[1]) report_mismatch("normal_y", normal_y, w.nrm[1]);
				if (normal_z != w.nrm[2]) report_mismatch("normal_z", normal_z, w.nrm[2]);
				if (tangent_x != w.tan[0]) report_mismatch("tangent_x", tangent_x, w.tan[0]);
				if (tangent_y != w.tan[1]) report_mismatch("tangent_y", tangent_y, w.tan[1]);
				if (tangent_z != w.tan[2]) report_mismatch("tangent_z", tangent_z, w.tan[2]);
				if (bitangent_x != w.btn[0])
					report_mismatch("bitangent_x", bitangent_x, w.btn[0]);
				if (bitangent_y != w.btn[1])
					report_mismatch("bitangent_y", bitangent_y, w.btn[1]);
				if (bitangent_z != w.btn[2])
					report_mismatch("bitangent_z", bitangent_z, w.btn[2]);
				if (frame_status != w.status)
					report_mismatch("frame_status", {30'b0, frame_status}, {30'b0, w.status});
				if (w.status & ST_ZERO_AREA) flat_seen++;
				if (w.status & ST_ZERO_DET) no_det_seen++;
			end
			frames_seen++;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_basic_frames();
		test_degenerate();
		test_extremes();
		test_random(542);
		in_valid <= 1'b0;
		while (pending_frames.size() != 0) @(posedge clk);
		repeat (2000) @(posedge clk);
		$display("Checked %0d frames: %0d with zero area, %0d with zero uv determinant.",
			frames_seen, flat_seen, no_det_seen);
		if (error_count == 0)
			$display("triangle_normal_tangent_frame test passed");
		else
			$display("triangle_normal_tangent_frame test failed");
		$finish;
	end

	initial begin
		#200_000_000;
		$display("Timed out with %0d frames outstanding.", pending_frames.size());
		$display("triangle_normal_tangent_frame test failed");
		$finish;
	end

endmodule
